// ----- rtl/pfde_pkg.sv -----
package pfde_pkg;

   // Result streams
   localparam logic [1:0] STREAM_PAGE     = 2'd0;
   localparam logic [1:0] STREAM_MASK     = 2'd1;
   localparam logic [1:0] STREAM_SPARSE   = 2'd2;
   localparam logic [1:0] STREAM_PRESENCE = 2'd3;

   // Register map, indexed by csr_paddr[2]
   localparam int         CSR_ADDR_W      = 3;
   localparam logic       REG_FRAME_WIDTH = 1'b0;
   localparam logic       REG_PAGE_ROWS   = 1'b1;
   localparam logic [7:0] FRAME_WIDTH_RST = 8'd128;
   localparam logic [3:0] PAGE_ROWS_RST   = 4'd8;

   // Result queue sizing
   localparam int MAX_RESULTS = 4;
   localparam int RCNT_W      = 3;
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = 3;
   localparam int QCNT_W      = 4;

   typedef struct packed {
      logic [1:0] stream;
      logic [7:0] value;
      logic       last;
   } result_type;

   typedef struct packed {
      logic [RCNT_W-1:0]                count;
      result_type [MAX_RESULTS-1:0]     entry;
   } push_type;

endpackage

// ----- rtl/pfde_ram.sv -----
module pfde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- rtl/pfde_out_queue.sv -----
module pfde_out_queue
   import pfde_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_stream,
   output logic [7:0] rsp_value,
   output logic       rsp_last
);

   localparam logic [QCNT_W-1:0] ROOM_LIMIT = QCNT_W'(QUEUE_DEPTH - MAX_RESULTS);

   result_type        q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              pop;

   assign room       = (count_ff <= ROOM_LIMIT);
   assign rsp_valid  = (count_ff != '0);
   assign pop        = rsp_valid && rsp_ready;
   assign rsp_stream = q_ff[rd_ptr_ff].stream;
   assign rsp_value  = q_ff[rd_ptr_ff].value;
   assign rsp_last   = q_ff[rd_ptr_ff].last;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + QCNT_W'(push.count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Append up to four words in the same cycle
   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (RCNT_W'(k) < push.count) begin
            q_ff[wr_ptr_ff + QPTR_W'(k)] <= push.entry[k];
         end
      end
   end

endmodule

// ----- rtl/pfde_delta_core.sv -----
module pfde_delta_core
   import pfde_pkg::*;
#(
   parameter int MAX_COLUMNS   = 128,
   parameter int MAX_PAGE_ROWS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] frame_width,
   input  logic [3:0] page_rows,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_page_byte,
   input  logic       room,
   output push_type   push
);

   localparam int COL_W  = $clog2(MAX_COLUMNS);
   localparam int ROW_W  = (MAX_PAGE_ROWS > 1) ? $clog2(MAX_PAGE_ROWS) : 1;
   localparam int DEPTH  = MAX_COLUMNS * MAX_PAGE_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [8:0]        MAXC = 9'(MAX_COLUMNS);
   localparam logic [3:0]        MAXR = 4'(MAX_PAGE_ROWS);
   localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(MAX_COLUMNS);

   // Position and frame state
   logic [COL_W-1:0] col_pos_ff, col_pos_in;
   logic [ROW_W-1:0] row_pos_ff, row_pos_in;
   logic             have_prev_ff, have_prev_in;

   // Compare stage
   logic              s1_valid_ff;
   logic [7:0]        s1_byte_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic              s1_last_col_ff;
   logic              s1_last_row_ff;
   logic              s1_first_ff;

   // Last write to each store, for a read that overlapped it
   logic              pf_fwd_valid_ff;
   logic [ADDR_W-1:0] pf_fwd_addr_ff;
   logic [7:0]        pf_fwd_data_ff;
   logic              mk_fwd_valid_ff;
   logic [COL_W-1:0]  mk_fwd_addr_ff;
   logic [7:0]        mk_fwd_data_ff;

   logic [MAX_COLUMNS-1:0] mask_valid_ff;
   logic [7:0]             presence_ff, presence_in;

   logic [8:0]        eff_w;
   logic [3:0]        eff_r;
   logic              last_col, last_row;
   logic [ADDR_W-1:0] addr;
   logic              req_fire, s1_fire;
   logic [7:0]        pf_rd_data, mk_rd_data;
   logic [7:0]        prev_byte, mask_old, mask_new, mask_wr;
   logic              changed, emit_presence;
   logic [7:0]        presence_set;
   logic [RCNT_W-1:0] n;
   result_type [MAX_RESULTS-1:0] ent;

   // Clamp the registers and locate the incoming word
   always_comb begin
      if (frame_width == 8'd0) begin
         eff_w = 9'd1;
      end else if ({1'b0, frame_width} > MAXC) begin
         eff_w = MAXC;
      end else begin
         eff_w = {1'b0, frame_width};
      end
      if (page_rows == 4'd0) begin
         eff_r = 4'd1;
      end else if (page_rows > MAXR) begin
         eff_r = MAXR;
      end else begin
         eff_r = page_rows;
      end
      last_col = (9'(col_pos_ff) + 9'd1) >= eff_w;
      last_row = (4'(row_pos_ff) + 4'd1) >= eff_r;
      addr     = ADDR_W'(row_pos_ff) * ROW_STRIDE + ADDR_W'(col_pos_ff);
   end

   assign s1_fire   = s1_valid_ff && room;
   assign req_ready = !s1_valid_ff || room;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      col_pos_in   = col_pos_ff;
      row_pos_in   = row_pos_ff;
      have_prev_in = have_prev_ff;
      if (req_fire) begin
         if (last_col) begin
            col_pos_in = '0;
            if (last_row) begin
               row_pos_in   = '0;
               have_prev_in = 1'b1;
            end else begin
               row_pos_in = row_pos_ff + ROW_W'(1);
            end
         end else begin
            col_pos_in = col_pos_ff + COL_W'(1);
         end
      end
   end

   pfde_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_frame_store (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_byte_ff),
      .rd_en   (req_fire),
      .rd_addr (addr),
      .rd_data (pf_rd_data)
   );

   pfde_ram #(.WIDTH(8), .DEPTH(MAX_COLUMNS)) u_mask_store (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_col_ff),
      .wr_data (mask_wr),
      .rd_en   (req_fire),
      .rd_addr (col_pos_ff),
      .rd_data (mk_rd_data)
   );

   // Compare, update the mask and gather the results
   always_comb begin
      prev_byte = (pf_fwd_valid_ff && pf_fwd_addr_ff == s1_addr_ff) ? pf_fwd_data_ff
                                                                    : pf_rd_data;
      changed   = s1_first_ff || (prev_byte != s1_byte_ff);
      if (!mask_valid_ff[s1_col_ff]) begin
         mask_old = 8'd0;
      end else if (mk_fwd_valid_ff && mk_fwd_addr_ff == s1_col_ff) begin
         mask_old = mk_fwd_data_ff;
      end else begin
         mask_old = mk_rd_data;
      end
      mask_new = mask_old | (changed ? (8'd1 << s1_row_ff) : 8'd0);
      mask_wr  = s1_last_row_ff ? 8'd0 : mask_new;

      presence_set  = presence_ff
                    | ((s1_last_row_ff && mask_new != 8'd0) ? (8'd1 << s1_col_ff[2:0]) : 8'd0);
      emit_presence = s1_last_row_ff && (s1_col_ff[2:0] == 3'b111 || s1_last_col_ff);
      presence_in   = presence_ff;
      if (s1_fire) begin
         presence_in = emit_presence ? 8'd0 : presence_set;
      end

      n   = '0;
      ent = '0;
      if (changed) begin
         ent[n[1:0]] = '{stream: STREAM_PAGE, value: s1_byte_ff, last: 1'b0};
         n = n + RCNT_W'(1);
      end
      if (s1_last_row_ff) begin
         ent[n[1:0]] = '{stream: STREAM_MASK, value: mask_new, last: 1'b0};
         n = n + RCNT_W'(1);
         if (mask_new != 8'd0) begin
            ent[n[1:0]] = '{stream: STREAM_SPARSE, value: mask_new, last: 1'b0};
            n = n + RCNT_W'(1);
         end
      end
      if (emit_presence) begin
         ent[n[1:0]] = '{stream: STREAM_PRESENCE, value: presence_set, last: 1'b0};
         n = n + RCNT_W'(1);
      end
      if (n != '0) begin
         ent[2'(n - RCNT_W'(1))].last = 1'b1;
      end

      push.entry = ent;
      push.count = s1_fire ? n : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff      <= '0;
         row_pos_ff      <= '0;
         have_prev_ff    <= 1'b0;
         s1_valid_ff     <= 1'b0;
         pf_fwd_valid_ff <= 1'b0;
         mk_fwd_valid_ff <= 1'b0;
         mask_valid_ff   <= '0;
         presence_ff     <= 8'd0;
      end else begin
         col_pos_ff   <= col_pos_in;
         row_pos_ff   <= row_pos_in;
         have_prev_ff <= have_prev_in;
         presence_ff  <= presence_in;
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            pf_fwd_valid_ff          <= 1'b1;
            mk_fwd_valid_ff          <= 1'b1;
            mask_valid_ff[s1_col_ff] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff     <= req_page_byte;
         s1_addr_ff     <= addr;
         s1_col_ff      <= col_pos_ff;
         s1_row_ff      <= row_pos_ff;
         s1_last_col_ff <= last_col;
         s1_last_row_ff <= last_row;
         s1_first_ff    <= !have_prev_ff;
      end
      if (s1_fire) begin
         pf_fwd_addr_ff <= s1_addr_ff;
         pf_fwd_data_ff <= s1_byte_ff;
         mk_fwd_addr_ff <= s1_col_ff;
         mk_fwd_data_ff <= mask_wr;
      end
   end

endmodule

// ----- rtl/page_frame_delta_encoder.sv -----
// Page frame delta encoder. Feed page bytes of a monochrome frame row by row,
// column by column within a page row; each byte is compared with the same byte
// of the previous frame held in an on-chip frame store. Changed bytes come out
// on stream 0, and on the last page row each column also gives its change mask
// (stream 1), the mask again if nonzero (stream 2) and, every eighth column or
// at the row end, a packed presence byte (stream 3); rsp_last marks the final
// word of one input byte. Throughput is one input byte per cycle as long as the
// result side keeps up: each input produces at most one word outside the last
// page row, but up to four on it, and the result port drains one word a cycle,
// so the last page row runs at a lower byte rate. An accepted byte first passes
// through the registered read of the frame store and mask store, then through
// the compare and write-back into an eight-word result queue. The first frame
// after reset reports every byte as changed. The frame store needs no clearing
// pass; column masks reset through per-column valid bits. Write frame_width
// (address 0) and page_rows (address 4) only while the block is idle.
module page_frame_delta_encoder
   import pfde_pkg::*;
#(
   parameter int MAX_COLUMNS   = 128,
   parameter int MAX_PAGE_ROWS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input words
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_page_byte,
   // Result words
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_stream,
   output logic [7:0]            rsp_value,
   output logic                  rsp_last,
   // Register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [7:0] frame_width_ff, frame_width_in;
   logic [3:0] page_rows_ff, page_rows_in;
   logic       csr_write;
   logic       room;
   push_type   push;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Decode register writes; paddr[2] selects the register
   always_comb begin
      frame_width_in = frame_width_ff;
      page_rows_in   = page_rows_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_FRAME_WIDTH: frame_width_in = csr_pwdata[7:0];
            REG_PAGE_ROWS:   page_rows_in   = csr_pwdata[3:0];
            default: begin
               frame_width_in = frame_width_ff;
               page_rows_in   = page_rows_ff;
            end
         endcase
      end
   end

   // Return the stored register value
   always_comb begin
      case (csr_paddr[2])
         REG_FRAME_WIDTH: csr_prdata = {24'd0, frame_width_ff};
         REG_PAGE_ROWS:   csr_prdata = {28'd0, page_rows_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= FRAME_WIDTH_RST;
         page_rows_ff   <= PAGE_ROWS_RST;
      end else begin
         frame_width_ff <= frame_width_in;
         page_rows_ff   <= page_rows_in;
      end
   end

   // Compare against the frame store and build the result words
   pfde_delta_core #(
      .MAX_COLUMNS   (MAX_COLUMNS),
      .MAX_PAGE_ROWS (MAX_PAGE_ROWS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .frame_width   (frame_width_ff),
      .page_rows     (page_rows_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_page_byte (req_page_byte),
      .room          (room),
      .push          (push)
   );

   // Hold result words until the consumer takes them
   pfde_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_stream (rsp_stream),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_last)
   );

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
   import pfde_pkg::*;

   // Keep the block at its default size so the predictor indexes the
   // frame store the same way the block does.
   localparam int COLUMNS   = 128;
   localparam int PAGE_ROWS = 8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_page_byte = '0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_stream;
   logic [7:0]            rsp_value;
   logic                  rsp_last;

   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // Page bytes waiting to go out, and the result words still owed.
   logic [7:0]            pending_bytes [$];
   result_type            expected_words [$];

   // Percent of cycles in which each side holds off.
   int unsigned           send_idle_pct = 34;
   int unsigned           recv_idle_pct = 68;

   int unsigned           error_count = 0;
   int unsigned           bytes_queued = 0;
   int unsigned           register_writes = 0;
   int unsigned           stream_count [4] = '{default: 0};
   result_type            oldest_word;

   // Predictor state: registers, frame store, per-column change masks,
   // packed presence bits and the position of the next page byte.
   logic [7:0]            frame_width_reg = FRAME_WIDTH_RST;
   logic [3:0]            page_rows_reg = PAGE_ROWS_RST;
   logic [7:0]            frame_store [COLUMNS*PAGE_ROWS];
   logic [7:0]            column_mask [COLUMNS] = '{default: '0};
   logic [7:0]            presence_bits = '0;
   bit                    frame_seen = 1'b0;
   int unsigned           column_pos = 0;
   int unsigned           row_pos = 0;

   // Stimulus-side copy of the last frame built, used to repeat bytes so
   // that unchanged bytes are common after the first frame of a setting.
   logic [7:0]            frame_copy [COLUMNS*PAGE_ROWS];

   page_frame_delta_encoder #(
      .MAX_COLUMNS   (COLUMNS),
      .MAX_PAGE_ROWS (PAGE_ROWS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_page_byte (req_page_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_stream    (rsp_stream),
      .rsp_value     (rsp_value),
      .rsp_last      (rsp_last),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #10 clock = ~clock;

   // Clamp the registers the way the block does: zero acts as one,
   // anything past the maximum acts as the maximum.
   function automatic int unsigned active_columns();
      if (frame_width_reg == 0) return 1;
      if (frame_width_reg > COLUMNS) return COLUMNS;
      return 32'(frame_width_reg);
   endfunction

   function automatic int unsigned active_rows();
      if (page_rows_reg == 0) return 1;
      if (page_rows_reg > PAGE_ROWS) return PAGE_ROWS;
      return 32'(page_rows_reg);
   endfunction

   // Append one owed word behind those already queued.
   function automatic void owe_word(input logic [1:0] stream, input logic [7:0] value);
      result_type word;
      word.stream = stream;
      word.value  = value;
      word.last   = 1'b0;
      expected_words.insert(expected_words.size(), word);
   endfunction

   // Work out the words one accepted page byte causes and queue them.
   function automatic void encode_page_byte(input logic [7:0] page_byte);
      int unsigned col;
      int unsigned row;
      int unsigned addr;
      int unsigned first;
      logic [7:0]  mask;
      bit          last_col;
      bit          last_row;
      result_type  word;
      col      = column_pos % COLUMNS;
      row      = row_pos % PAGE_ROWS;
      addr     = row * COLUMNS + col;
      first    = expected_words.size();
      // A position at or past the limit counts as the last one, so a
      // register change in the middle of a frame wraps right after it.
      last_col = (col + 1 >= active_columns());
      last_row = (row + 1 >= active_rows());

      // Every byte of the first frame is a change.
      if (!frame_seen || frame_store[addr] != page_byte) begin
         owe_word(STREAM_PAGE, page_byte);
         column_mask[col][row] = 1'b1;
      end
      frame_store[addr] = page_byte;

      // On the last page row, flush the column mask and pack presence bits.
      if (last_row) begin
         mask = column_mask[col];
         owe_word(STREAM_MASK, mask);
         if (mask != 0) begin
            owe_word(STREAM_SPARSE, mask);
            presence_bits[col % 8] = 1'b1;
         end
         column_mask[col] = '0;
         if (col % 8 == 7 || last_col) begin
            owe_word(STREAM_PRESENCE, presence_bits);
            presence_bits = '0;
         end
      end

      if (last_col) begin
         column_pos = 0;
         if (last_row) begin
            row_pos    = 0;
            frame_seen = 1'b1;
         end else begin
            row_pos = row + 1;
         end
      end else begin
         column_pos = col + 1;
         row_pos    = row;
      end

      // Mark the final word of this byte.
      if (expected_words.size() > first) begin
         word      = expected_words[expected_words.size() - 1];
         word.last = 1'b1;
         expected_words[expected_words.size() - 1] = word;
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Driver: predict on acceptance, then load the next page byte or idle.
   // Valid only drops after an accepted word, never while one is pending.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            encode_page_byte(req_page_byte);
         end
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid     <= 1'b1;
               req_page_byte <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted word with the oldest one owed, and
   // stall the result side at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word stream %0d value %02h last %0b",
                                         rsp_stream, rsp_value, rsp_last));
            end else begin
               oldest_word = expected_words.pop_front();
               if (rsp_stream !== oldest_word.stream)
                  report_mismatch($sformatf("stream %0d, want %0d",
                                            rsp_stream, oldest_word.stream));
               if (rsp_value !== oldest_word.value)
                  report_mismatch($sformatf("value %02h on stream %0d, want %02h",
                                            rsp_value, oldest_word.stream,
                                            oldest_word.value));
               if (rsp_last !== oldest_word.last)
                  report_mismatch($sformatf("last %0b on stream %0d, want %0b",
                                            rsp_last, oldest_word.stream,
                                            oldest_word.last));
               stream_count[oldest_word.stream]++;
            end
         end
         rsp_ready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   // Hold until every byte went out and every word came back, then give a
   // byte with no word time to leave the two-stage pipeline.
   task automatic wait_for_drain();
      while (pending_bytes.size() != 0 || req_valid || expected_words.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the value at the
   // edge that closes the access. Fill the unused upper bits with noise.
   task automatic write_register(input logic reg_index, input logic [7:0] setting);
      logic [31:0] noise;
      noise = $urandom();
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      if (reg_index == REG_FRAME_WIDTH)
         csr_pwdata <= {noise[31:8], setting};
      else
         csr_pwdata <= {noise[31:4], setting[3:0]};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_index == REG_FRAME_WIDTH)
         frame_width_reg = setting;
      else
         page_rows_reg = setting[3:0];
      register_writes++;
   endtask

   task automatic send_byte(input logic [7:0] page_byte);
      pending_bytes.insert(pending_bytes.size(), page_byte);
      bytes_queued++;
   endtask

   // Queue whole frames at the current size, each a mutation of the one
   // before, then a partial frame of random bytes to break the sequence.
   task automatic queue_frames(input int unsigned frames, input int unsigned tail);
      int unsigned size;
      logic [7:0]  page_byte;
      size = active_columns() * active_rows();
      for (int unsigned f = 0; f < frames; f++) begin
         for (int unsigned i = 0; i < size; i++) begin
            if (f == 0 || $urandom_range(99) < 35)
               page_byte = 8'($urandom_range(255));
            else
               page_byte = frame_copy[i];
            frame_copy[i] = page_byte;
            send_byte(page_byte);
         end
      end
      for (int unsigned i = 0; i < tail; i++)
         send_byte(8'($urandom_range(255)));
   endtask

   initial begin
      int unsigned random_start;
      logic [7:0]  width_code;
      logic [7:0]  rows_code;
      int unsigned frame_size;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // First frame eight columns by eight page rows: every byte is a
      // change, and it covers every place a later frame reaches, so no
      // later compare hits an empty entry of the frame store.
      write_register(REG_FRAME_WIDTH, 8'd8);
      queue_frames(1, 0);
      wait_for_drain();

      // One column, one page row via zero settings: unchanged and changed
      // bytes in turn, with both extremes of the byte.
      write_register(REG_FRAME_WIDTH, 8'd0);
      write_register(REG_PAGE_ROWS, 8'd0);
      send_byte(frame_copy[0]);
      send_byte(~frame_copy[0]);
      send_byte(~frame_copy[0]);
      send_byte(8'h00);
      send_byte(8'hFF);
      wait_for_drain();

      // Oversized settings act as the maximum; advance three columns.
      write_register(REG_FRAME_WIDTH, 8'd255);
      write_register(REG_PAGE_ROWS, 8'd15);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'($urandom_range(255)));
      wait_for_drain();

      // Shrink the width mid-frame: the current column is past the new
      // limit, so the next byte ends the page row.
      write_register(REG_FRAME_WIDTH, 8'd2);
      send_byte(8'($urandom_range(255)));
      wait_for_drain();

      // Shrink the rows mid-frame: the current row now counts as the last.
      write_register(REG_PAGE_ROWS, 8'd1);
      repeat (4) send_byte(8'($urandom_range(255)));
      wait_for_drain();

      // A single column eight rows tall.
      write_register(REG_FRAME_WIDTH, 8'd1);
      write_register(REG_PAGE_ROWS, 8'd8);
      repeat (8) send_byte(8'($urandom_range(255)));
      wait_for_drain();

      // Random settings with mostly well-formed frames; the sender idles
      // more than the receiver for the first half, neither for the second.
      send_idle_pct = 68;
      recv_idle_pct = 34;
      random_start  = bytes_queued;
      while (bytes_queued - random_start < 30) begin
         if (bytes_queued - random_start >= 15) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         rows_code = ($urandom_range(9) < 2) ? 8'($urandom_range(9, 15))
                                             : 8'($urandom_range(0, 4));
         case ($urandom_range(5))
            0: width_code = 8'd0;
            1: width_code = 8'd1;
            default: width_code = 8'($urandom_range(2, 8));
         endcase
         // Keep tall frames narrow so most items use small frames.
         if (rows_code >= 5)
            width_code = 8'($urandom_range(0, 3));
         write_register(REG_FRAME_WIDTH, width_code);
         write_register(REG_PAGE_ROWS, rows_code);
         frame_size = active_columns() * active_rows();
         queue_frames($urandom_range(1, 2),
                      ($urandom_range(3) == 0) ? $urandom_range(0, frame_size) : 0);
         wait_for_drain();
      end

      repeat (10) @(posedge clock);
      $display("sent %0d page bytes with %0d register writes across several frame sizes",
               bytes_queued, register_writes);
      $display("words checked: %0d page, %0d mask, %0d sparse, %0d presence",
               stream_count[STREAM_PAGE], stream_count[STREAM_MASK],
               stream_count[STREAM_SPARSE], stream_count[STREAM_PRESENCE]);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Bound the run well past the slowest legal drain.
   initial begin
      #(20 * 400000);
      $display("TB_ERROR");
      $finish;
   end

endmodule
